FILE: hdl/hmf_pkg.sv
// shared types, constants and codes for the height map hole fill block
`default_nettype none
package hmf_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CFG_W       = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // reciprocal of three for sums up to 1020: q = (sum * RECIP3) >> RECIP3_SH
  localparam int RECIP3      = 683;
  localparam int RECIP3_SH   = 11;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // neighbour order in nbr_ok and in the read sequence
  localparam logic [1:0] NBR_LEFT  = 2'd0;
  localparam logic [1:0] NBR_RIGHT = 2'd1;
  localparam logic [1:0] NBR_UP    = 2'd2;
  localparam logic [1:0] NBR_DOWN  = 2'd3;

  typedef struct packed {
    logic              func;
    logic              outside;
    logic [3:0]        nbr_ok;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        pixel_value;
  } hmf_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CTR,
    ST_NBR,
    ST_DIV,
    ST_OUT
  } hmf_state_t;

endpackage
`default_nettype wire

FILE: hdl/hmf_if.sv
// valid/ready channel interfaces for input beats and result beats
`default_nettype none
interface hmf_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] pixel_value;

  modport source (output valid, output func, output col, output row, output pixel_value,
                  input ready);
  modport sink   (input valid, input func, input col, input row, input pixel_value,
                  output ready);
endinterface

interface hmf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filled_value;
  logic        is_empty_spot;
  logic [7:0]  lowest_nonzero;
  logic        out_of_range;

  modport source (output valid, output filled_value, output is_empty_spot,
                  output lowest_nonzero, output out_of_range, input ready);
  modport sink   (input valid, input filled_value, input is_empty_spot,
                  input lowest_nonzero, input out_of_range, output ready);
endinterface
`default_nettype wire

FILE: hdl/height_map_hole_fill.sv
// top level: front end, job queue and back end of the height map hole fill block
// sequence: an out-of-range query goes straight to the result register, a nonzero pixel
//   is returned after the centre read, else the four neighbours are read and averaged
// throughput: the store has one read port; a write is taken while idle, and a query
//   holds the back end until its result is loaded (one neighbour read per cycle)
// reset: rst_n clears control, config to 256 x 256, minimum and flags; the store keeps its data
`default_nettype none
module height_map_hole_fill (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  hmf_in_if.sink                         in_ch,
  hmf_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [hmf_pkg::CFG_W-1:0] cfg_data
);

  logic              push, q_full, q_pop, q_valid;
  hmf_pkg::hmf_job_t push_job, pop_job;

  hmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  hmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_valid)
  );

  hmf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

FILE: hdl/hmf_front.sv
// front end: config registers, range check and address/neighbour classification
`default_nettype none
module hmf_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  hmf_in_if.sink                         in_ch,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [hmf_pkg::CFG_W-1:0] cfg_data,
  output logic                           push,
  output hmf_pkg::hmf_job_t              push_job,
  input  wire logic                      q_full
);

  logic [hmf_pkg::CFG_W-1:0] map_width_r;
  logic [hmf_pkg::CFG_W-1:0] map_height_r;
  logic                      col_out, row_out;
  logic                      left_ok, right_ok, up_ok, down_ok;
  logic [hmf_pkg::CFG_W-1:0] col_p1, row_p1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= hmf_pkg::CFG_W'(256);
      map_height_r <= hmf_pkg::CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hmf_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_data;
        hmf_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_p1   = {1'b0, in_ch.col} + hmf_pkg::CFG_W'(1);
    row_p1   = {1'b0, in_ch.row} + hmf_pkg::CFG_W'(1);
    // map in use is min(register, store size)
    col_out  = ({1'b0, in_ch.col} >= map_width_r) || (32'(in_ch.col) >= hmf_pkg::MAX_WIDTH);
    row_out  = ({1'b0, in_ch.row} >= map_height_r) || (32'(in_ch.row) >= hmf_pkg::MAX_HEIGHT);
    left_ok  = (in_ch.col != 8'd0);
    right_ok = (col_p1 < map_width_r) && (32'(col_p1) < hmf_pkg::MAX_WIDTH);
    up_ok    = (in_ch.row != 8'd0);
    down_ok  = (row_p1 < map_height_r) && (32'(row_p1) < hmf_pkg::MAX_HEIGHT);

    push_job.func        = in_ch.func;
    push_job.outside     = col_out || row_out;
    push_job.nbr_ok      = {down_ok, up_ok, right_ok, left_ok};
    push_job.addr        = hmf_pkg::ADDR_W'(32'(in_ch.row) * hmf_pkg::MAX_WIDTH
                                            + 32'(in_ch.col));
    push_job.pixel_value = in_ch.pixel_value;
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

endmodule
`default_nettype wire

FILE: hdl/hmf_queue.sv
// short job queue between front end and back end
`default_nettype none
module hmf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hmf_pkg::hmf_job_t push_job,
  output logic                   full,
  input  wire logic              pop,
  output hmf_pkg::hmf_job_t      pop_job,
  output logic                   not_empty
);

  hmf_pkg::hmf_job_t             slot_r [hmf_pkg::QUEUE_DEPTH];
  logic [hmf_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [hmf_pkg::QCNT_W-1:0]    cnt_r;

  assign full      = (32'(cnt_r) == hmf_pkg::QUEUE_DEPTH);
  assign not_empty = (cnt_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == hmf_pkg::QUEUE_DEPTH - 1) ? '0
                    : wr_ptr_r + hmf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == hmf_pkg::QUEUE_DEPTH - 1) ? '0
                    : rd_ptr_r + hmf_pkg::QPTR_W'(1);
      end
      if (push && !pop)      cnt_r <= cnt_r + hmf_pkg::QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - hmf_pkg::QCNT_W'(1);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hmf_back.sv
// back end: pixel store, neighbour read sequencer, mean and result register
`default_nettype none
module hmf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire hmf_pkg::hmf_job_t q_job,
  output logic                   q_pop,
  hmf_out_if.source              out_ch
);

  logic [7:0] store_mem [hmf_pkg::MAX_WIDTH * hmf_pkg::MAX_HEIGHT];

  hmf_pkg::hmf_state_t         state_r, state_nxt;
  hmf_pkg::hmf_job_t           job_r;
  logic [7:0]                  rd_data_r;
  logic [hmf_pkg::ADDR_W-1:0]  rd_addr;
  logic                        mem_we;
  logic                        out_free, out_load;
  logic [1:0]                  idx_r;
  logic [9:0]                  sum_r;
  logic [2:0]                  cnt_r;
  logic                        has_data_r, seen_r;
  logic [7:0]                  least_r;
  logic                        out_valid_r;
  logic [15:0]                 res_value_r;
  logic                        res_empty_r, res_oor_r;
  logic [7:0]                  res_low_r;
  logic [15:0]                 mean;
  logic [19:0]                 prod3;
  logic [8:0]                  q3;
  logic [9:0]                  rem3;
  logic [17:0]                 sum_sh;

  function automatic logic [hmf_pkg::ADDR_W-1:0] nbr_addr(
    input logic [hmf_pkg::ADDR_W-1:0] base,
    input logic [1:0]                 which
  );
    logic [hmf_pkg::ADDR_W-1:0] a;
    case (which)
      hmf_pkg::NBR_LEFT:  a = base - hmf_pkg::ADDR_W'(1);
      hmf_pkg::NBR_RIGHT: a = base + hmf_pkg::ADDR_W'(1);
      hmf_pkg::NBR_UP:    a = base - hmf_pkg::ADDR_W'(hmf_pkg::MAX_WIDTH);
      default:            a = base + hmf_pkg::ADDR_W'(hmf_pkg::MAX_WIDTH);
    endcase
    return a;
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hmf_pkg::ST_IDLE: begin
        if (q_valid && q_job.func == hmf_pkg::FUNC_QUERY) begin
          state_nxt = q_job.outside ? hmf_pkg::ST_OUT : hmf_pkg::ST_CTR;
        end
      end
      hmf_pkg::ST_CTR:  state_nxt = (rd_data_r != 8'd0) ? hmf_pkg::ST_OUT : hmf_pkg::ST_NBR;
      hmf_pkg::ST_NBR:  if (idx_r == hmf_pkg::NBR_DOWN) state_nxt = hmf_pkg::ST_DIV;
      hmf_pkg::ST_DIV:  state_nxt = hmf_pkg::ST_OUT;
      hmf_pkg::ST_OUT:  if (out_free) state_nxt = hmf_pkg::ST_IDLE;
      default:          state_nxt = hmf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    rd_addr  = job_r.addr;
    unique case (state_r)
      hmf_pkg::ST_IDLE: begin
        q_pop   = q_valid;
        mem_we  = q_valid && q_job.func == hmf_pkg::FUNC_WRITE && !q_job.outside;
        rd_addr = q_job.addr;
      end
      hmf_pkg::ST_CTR:  rd_addr = nbr_addr(job_r.addr, hmf_pkg::NBR_LEFT);
      hmf_pkg::ST_NBR:  rd_addr = nbr_addr(job_r.addr, idx_r + 2'd1);
      hmf_pkg::ST_DIV:  ;
      hmf_pkg::ST_OUT:  out_load = out_free;
      default:          ;
    endcase
  end

  // mean of up to four neighbours in Q8.8, count three via reciprocal
  always_comb begin
    sum_sh = {sum_r, 8'd0};
    prod3  = 20'(sum_r) * 20'(hmf_pkg::RECIP3);
    q3     = prod3[hmf_pkg::RECIP3_SH +: 9];
    rem3   = sum_r - (10'(q3) * 10'd3);
    case (cnt_r)
      3'd1:    mean = sum_sh[15:0];
      3'd2:    mean = sum_sh[16:1];
      3'd3: begin
        mean = {q3[7:0], 8'd0};
        if (rem3[1:0] == 2'd1)      mean = mean + 16'd85;
        else if (rem3[1:0] == 2'd2) mean = mean + 16'd170;
      end
      3'd4:    mean = sum_sh[17:2];
      default: mean = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[q_job.addr] <= q_job.pixel_value;
    rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hmf_pkg::ST_IDLE;
      has_data_r  <= 1'b0;
      seen_r      <= 1'b0;
      least_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        has_data_r <= 1'b1;
        if (q_job.pixel_value != 8'd0 && (!seen_r || q_job.pixel_value < least_r)) begin
          least_r <= q_job.pixel_value;
          seen_r  <= 1'b1;
        end
      end
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      hmf_pkg::ST_IDLE: begin
        job_r       <= q_job;
        idx_r       <= hmf_pkg::NBR_LEFT;
        sum_r       <= 10'd0;
        cnt_r       <= 3'd0;
        res_value_r <= 16'd0;
        res_empty_r <= 1'b0;
        res_oor_r   <= q_job.outside;
      end
      hmf_pkg::ST_CTR: begin
        res_empty_r <= has_data_r && rd_data_r == 8'd0;
        res_value_r <= {rd_data_r, 8'd0};
      end
      hmf_pkg::ST_NBR: begin
        if (job_r.nbr_ok[idx_r] && rd_data_r != 8'd0) begin
          sum_r <= sum_r + 10'(rd_data_r);
          cnt_r <= cnt_r + 3'd1;
        end
        idx_r <= idx_r + 2'd1;
      end
      hmf_pkg::ST_DIV:  res_value_r <= mean;
      hmf_pkg::ST_OUT:  ;
      default:          ;
    endcase
    if (out_load) res_low_r <= least_r;
  end

  // result register is loaded from the working result fields
  logic [15:0] out_value_r;
  logic        out_empty_r, out_oor_r;
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= res_value_r;
      out_empty_r <= res_empty_r;
      out_oor_r   <= res_oor_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filled_value   = out_value_r;
  assign out_ch.is_empty_spot  = out_empty_r;
  assign out_ch.lowest_nonzero = res_low_r;
  assign out_ch.out_of_range   = out_oor_r;

endmodule
`default_nettype wire

FILE: hdl/hmf_checker.sv
// port-level checks on the result channel, bound to the top level
`default_nettype none
module hmf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] filled_value,
  input wire logic        is_empty_spot,
  input wire logic [7:0]  lowest_nonzero,
  input wire logic        out_of_range
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(filled_value) && $stable(is_empty_spot)
      && $stable(lowest_nonzero) && $stable(out_of_range))
    else $error("result payload changed while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> filled_value == 16'd0 && !is_empty_spot)
    else $error("out of range result carries data");

  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind height_map_hole_fill hmf_checker u_hmf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .filled_value   (out_ch.filled_value),
  .is_empty_spot  (out_ch.is_empty_spot),
  .lowest_nonzero (out_ch.lowest_nonzero),
  .out_of_range   (out_ch.out_of_range)
);
`default_nettype wire
